>>> sv/fcspt_pkg.sv
// Shared types and constants of the fixed-cycle signal phase tracker.
package fcspt_pkg;

    localparam int HourW   = 5;
    localparam int MinW    = 6;
    localparam int MsW     = 16;
    localparam int TimeW   = 27;
    localparam int PhaseW  = 22;
    localparam int CycleW  = 24;
    localparam int RedInW  = 23;
    localparam int LightW  = 2;
    localparam int AddrW   = 5;
    localparam int DataW   = 32;
    localparam int RegIdxW = 3;

    localparam int DivSteps = TimeW;
    localparam int CntW     = $clog2(DivSteps);

    localparam logic [TimeW-1:0] MsPerHour   = TimeW'(3600000);
    localparam logic [TimeW-1:0] MsPerMinute = TimeW'(60000);

    typedef enum logic [LightW-1:0] {
        LIGHT_UNKNOWN = 2'd0,
        LIGHT_GREEN   = 2'd1,
        LIGHT_RED     = 2'd2
    } light_t;

    typedef enum logic [RegIdxW-1:0] {
        REG_SCHEDULE_VALID = 3'd0,
        REG_START_TIME     = 3'd1,
        REG_GREEN          = 3'd2,
        REG_YELLOW         = 3'd3,
        REG_RED            = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic              schedule_valid;
        logic [TimeW-1:0]  start_time_ms;
        logic [PhaseW-1:0] green_ms;
        logic [PhaseW-1:0] yellow_ms;
        logic [PhaseW-1:0] red_ms;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic adjust;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic usable;
    } dp_status_t;

endpackage

>>> sv/fcspt_if.sv
// Valid/ready channel interfaces for time items and phase result items.
interface fcspt_in_if
    import fcspt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HourW-1:0]  hour_of_day;
    logic [MinW-1:0]   minute_of_hour;
    logic [MsW-1:0]    second_millis;

    modport source (output valid, output hour_of_day, output minute_of_hour,
                    output second_millis, input ready);
    modport sink   (input valid, input hour_of_day, input minute_of_hour,
                    input second_millis, output ready);
endinterface

interface fcspt_out_if
    import fcspt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [LightW-1:0]        light;
    logic                     announce;
    logic                     times_valid;
    logic [PhaseW-1:0]        phase_left_ms;
    logic signed [RedInW-1:0] red_in_ms;

    modport source (output valid, output light, output announce, output times_valid,
                    output phase_left_ms, output red_in_ms, input ready);
    modport sink   (input valid, input light, input announce, input times_valid,
                    input phase_left_ms, input red_in_ms, output ready);
endinterface

>>> sv/fixed_cycle_signal_phase_tracker_top.sv
// Top level of the fixed-cycle signal phase tracker.
// Once its item is accepted, a result is valid after setup, the 27-step restoring modulo
// over the cycle length, adjust and emit; with an unusable schedule setup goes to emit.
// A new item is taken only once the last one is emitted; a result still
// waiting does not block the next item, whose own result then waits until it is taken.
// Reset is asynchronous and active low; it clears control, configuration and the last light.
module fixed_cycle_signal_phase_tracker_top
    import fcspt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    fcspt_in_if.sink         in_ch,
    fcspt_out_if.source      out_ch
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    fcspt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcspt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    fcspt_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .hour_of_day    (in_ch.hour_of_day),
        .minute_of_hour (in_ch.minute_of_hour),
        .second_millis  (in_ch.second_millis),
        .light          (out_ch.light),
        .announce       (out_ch.announce),
        .times_valid    (out_ch.times_valid),
        .phase_left_ms  (out_ch.phase_left_ms),
        .red_in_ms      (out_ch.red_in_ms)
    );

endmodule

>>> sv/fcspt_regs.sv
// APB configuration registers of the phase tracker.
module fcspt_regs
    import fcspt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SCHEDULE_VALID: cfg_reg.schedule_valid <= pwdata[0];
                REG_START_TIME:     cfg_reg.start_time_ms  <= pwdata[TimeW-1:0];
                REG_GREEN:          cfg_reg.green_ms       <= pwdata[PhaseW-1:0];
                REG_YELLOW:         cfg_reg.yellow_ms      <= pwdata[PhaseW-1:0];
                REG_RED:            cfg_reg.red_ms         <= pwdata[PhaseW-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SCHEDULE_VALID: prdata = DataW'(cfg_reg.schedule_valid);
            REG_START_TIME:     prdata = DataW'(cfg_reg.start_time_ms);
            REG_GREEN:          prdata = DataW'(cfg_reg.green_ms);
            REG_YELLOW:         prdata = DataW'(cfg_reg.yellow_ms);
            REG_RED:            prdata = DataW'(cfg_reg.red_ms);
            default:            prdata = '0;
        endcase
    end

endmodule

>>> sv/fcspt_dp.sv
// Datapath: time of day, iterative floor modulo over the cycle, phase classification.
module fcspt_dp
    import fcspt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [HourW-1:0]         hour_of_day,
    input  logic [MinW-1:0]          minute_of_hour,
    input  logic [MsW-1:0]           second_millis,
    output logic [LightW-1:0]        light,
    output logic                     announce,
    output logic                     times_valid,
    output logic [PhaseW-1:0]        phase_left_ms,
    output logic signed [RedInW-1:0] red_in_ms
);

    logic [TimeW-1:0]         now_reg;
    logic                     usable_reg;
    logic                     neg_reg;
    logic [TimeW-1:0]         mag_reg;
    logic [CycleW-1:0]        cycle_reg;
    logic [CycleW-1:0]        rem_reg;
    logic [CycleW-1:0]        pos_reg;
    light_t                   last_light_reg;
    logic [LightW-1:0]        light_reg;
    logic                     announce_reg;
    logic                     times_valid_reg;
    logic [PhaseW-1:0]        phase_left_reg;
    logic signed [RedInW-1:0] red_in_reg;

    logic [TimeW-1:0]  now_next;
    logic              usable_next;
    logic [TimeW:0]    diff;
    logic [TimeW:0]    diff_neg;
    logic [CycleW:0]   trial;
    logic [CycleW:0]   trial_sub;
    logic [CycleW-1:0] pos_g;
    logic [CycleW-1:0] pos_r;
    logic              green_hit;
    logic              yellow_hit;
    light_t            light_next;
    logic [PhaseW-1:0] left_next;

    assign now_next = TimeW'(hour_of_day) * MsPerHour
                    + TimeW'(minute_of_hour) * MsPerMinute
                    + TimeW'(second_millis);
    assign usable_next = cfg.schedule_valid && (|cfg.green_ms) && (|cfg.yellow_ms)
                       && (|cfg.red_ms);
    assign status.usable = usable_reg;

    assign diff     = {1'b0, now_reg} - {1'b0, cfg.start_time_ms};
    assign diff_neg = -diff;

    assign trial     = {rem_reg, mag_reg[TimeW-1]};
    assign trial_sub = trial - {1'b0, cycle_reg};

    assign green_hit  = pos_reg < CycleW'(cfg.green_ms);
    assign pos_g      = pos_reg - CycleW'(cfg.green_ms);
    assign yellow_hit = pos_g < CycleW'(cfg.yellow_ms);
    assign pos_r      = pos_g - CycleW'(cfg.yellow_ms);

    always_comb
    begin
        if (!usable_reg)
        begin
            light_next = LIGHT_UNKNOWN;
            left_next  = '0;
        end
        else if (green_hit)
        begin
            light_next = LIGHT_GREEN;
            left_next  = cfg.green_ms - pos_reg[PhaseW-1:0];
        end
        else if (yellow_hit)
        begin
            light_next = LIGHT_RED;
            left_next  = cfg.yellow_ms - pos_g[PhaseW-1:0];
        end
        else
        begin
            light_next = LIGHT_RED;
            left_next  = cfg.red_ms - pos_r[PhaseW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg    <= now_next;
            usable_reg <= usable_next;
        end
        if (cmd.setup)
        begin
            neg_reg   <= diff[TimeW];
            mag_reg   <= diff[TimeW] ? diff_neg[TimeW-1:0] : diff[TimeW-1:0];
            cycle_reg <= CycleW'(cfg.green_ms) + CycleW'(cfg.yellow_ms)
                       + CycleW'(cfg.red_ms);
            rem_reg   <= '0;
        end
        if (cmd.step)
        begin
            rem_reg <= trial_sub[CycleW] ? trial[CycleW-1:0] : trial_sub[CycleW-1:0];
            mag_reg <= {mag_reg[TimeW-2:0], 1'b0};
        end
        if (cmd.adjust)
        begin
            pos_reg <= (neg_reg && (|rem_reg)) ? cycle_reg - rem_reg : rem_reg;
        end
        if (cmd.emit)
        begin
            light_reg       <= light_next;
            announce_reg    <= light_next != last_light_reg;
            times_valid_reg <= usable_reg;
            phase_left_reg  <= left_next;
            red_in_reg      <= (light_next == LIGHT_GREEN) ? RedInW'({1'b0, left_next})
                                                           : '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_light_reg <= LIGHT_UNKNOWN;
        end
        else if (cmd.emit)
        begin
            last_light_reg <= light_next;
        end
    end

    assign light         = light_reg;
    assign announce      = announce_reg;
    assign times_valid   = times_valid_reg;
    assign phase_left_ms = phase_left_reg;
    assign red_in_ms     = red_in_reg;

endmodule

>>> sv/fcspt_ctrl.sv
// Controller state machine that sequences the tracker datapath and the output handshake.
module fcspt_ctrl
    import fcspt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_ADJUST,
        ST_EMIT
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = status.usable ? ST_DIVIDE : ST_EMIT;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivSteps - 1))
                begin
                    state_next = ST_ADJUST;
                end
            end
            ST_ADJUST:
            begin
                cmd.adjust = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/fcspt_checker.sv
// Port-level checker for the phase tracker and its bind to the top level.
module fcspt_checker
    import fcspt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [LightW-1:0]        light,
    input logic                     times_valid,
    input logic [PhaseW-1:0]        phase_left_ms,
    input logic signed [RedInW-1:0] red_in_ms
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input accepted again while an item was in work.");

    a_unknown_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (light == LIGHT_UNKNOWN) |->
            !times_valid && (phase_left_ms == '0) && (red_in_ms == '1))
        else $error("Unknown light with meaningful time fields.");

    a_red_in_green_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (light != LIGHT_GREEN) |-> red_in_ms == '1)
        else $error("Time to red given outside green.");

    a_usable_has_light: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && times_valid |->
            (light == LIGHT_GREEN || light == LIGHT_RED) && (phase_left_ms != '0))
        else $error("Usable schedule without a known light or time left.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(light) && $stable(red_in_ms))
        else $error("Result item changed while stalled.");

endmodule

bind fixed_cycle_signal_phase_tracker_top fcspt_checker u_fcspt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .light         (out_ch.light),
    .times_valid   (out_ch.times_valid),
    .phase_left_ms (out_ch.phase_left_ms),
    .red_in_ms     (out_ch.red_in_ms)
);

>>> test/tb_fixed_cycle_signal_phase_tracker_top.sv
// Self-checking testbench: a directed table, then random schedules and times checked against a predictor.
module tb_fixed_cycle_signal_phase_tracker_top
    import fcspt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SpareRegIdx = 5;
    localparam int RandPhases  = 13;
    localparam int PhaseItems  = 150;
    localparam int QuietLimit  = 2000;
    localparam int DrainCycles = 40;
    localparam int DayMs       = 86400000;

    typedef struct packed {
        light_t                   light;
        logic                     announce;
        logic                     times_valid;
        logic [PhaseW-1:0]        phase_left_ms;
        logic signed [RedInW-1:0] red_in_ms;
    } phase_res_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_TIME
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [RegIdxW:0] reg_sel;
        logic [DataW-1:0] wdata;
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [MsW-1:0]   millis;
        logic             typed;
        phase_res_t       want;
    } step_row_t;

    logic             clk;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    fcspt_in_if  in_ch ();
    fcspt_out_if out_ch ();

    cfg_t       sched = '0;
    light_t     shown_light = LIGHT_UNKNOWN;
    phase_res_t pending_phases[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    bit         sender_burst = 1'b0;

    fixed_cycle_signal_phase_tracker_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic phase_res_t phase_is(light_t light, logic announce, logic times_valid,
                                            int left, int red_in);
        phase_res_t r;
        r.light         = light;
        r.announce      = announce;
        r.times_valid   = times_valid;
        r.phase_left_ms = PhaseW'(left);
        r.red_in_ms     = RedInW'(red_in);
        return r;
    endfunction

    function automatic step_row_t row_write(int idx, logic [DataW-1:0] val);
        step_row_t r;
        r         = '0;
        r.kind    = ROW_WRITE;
        r.reg_sel = (RegIdxW + 1)'(idx);
        r.wdata   = val;
        return r;
    endfunction

    function automatic step_row_t row_time(int h, int m, int ms);
        step_row_t r;
        r        = '0;
        r.kind   = ROW_TIME;
        r.hour   = HourW'(h);
        r.minute = MinW'(m);
        r.millis = MsW'(ms);
        return r;
    endfunction

    function automatic step_row_t row_time_is(int h, int m, int ms, phase_res_t want);
        step_row_t r;
        r       = row_time(h, m, ms);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic phase_res_t predict_phase(logic [HourW-1:0] h, logic [MinW-1:0] m,
                                                 logic [MsW-1:0] ms);
        phase_res_t r;
        longint     now_ms;
        longint     cyc;
        longint     pos;
        longint     left;
        longint     red_in;
        logic       usable;
        usable = sched.schedule_valid && sched.green_ms != 0 && sched.yellow_ms != 0
                 && sched.red_ms != 0;
        r.light = LIGHT_UNKNOWN;
        left    = 0;
        red_in  = -1;
        if (usable)
        begin
            now_ms = longint'(h) * longint'(MsPerHour) + longint'(m) * longint'(MsPerMinute)
                     + longint'(ms);
            cyc = longint'(sched.green_ms) + longint'(sched.yellow_ms) + longint'(sched.red_ms);
            pos = (now_ms - longint'(sched.start_time_ms)) % cyc;
            if (pos < 0)
                pos += cyc;
            if (pos < longint'(sched.green_ms))
            begin
                r.light = LIGHT_GREEN;
                left    = longint'(sched.green_ms) - pos;
                red_in  = left;
            end
            else
            begin
                r.light = LIGHT_RED;
                pos -= longint'(sched.green_ms);
                if (pos < longint'(sched.yellow_ms))
                    left = longint'(sched.yellow_ms) - pos;
                else
                    left = longint'(sched.red_ms) - (pos - longint'(sched.yellow_ms));
            end
        end
        r.announce      = (r.light != shown_light);
        r.times_valid   = usable;
        r.phase_left_ms = PhaseW'(left);
        r.red_in_ms     = RedInW'(red_in);
        shown_light     = r.light;
        return r;
    endfunction

    function automatic logic [DataW-1:0] draw_phase_len();
        case ($urandom_range(0, 19)) inside
            0:                       return '0;
            1:                       return $urandom;
            2:                       return DataW'(3600000);
            [3:8]:                   return $urandom_range(1, 40);
            [9:13]:                  return $urandom_range(1, 2000);
            default:                 return $urandom_range(1, 3600000);
        endcase
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_reg(input int idx, input logic [DataW-1:0] val);
        logic [DataW-1:0] readback;
        bit               known;
        known = 1'b1;
        case (idx)
            REG_SCHEDULE_VALID:
            begin
                sched.schedule_valid = val[0];
                readback = DataW'(sched.schedule_valid);
            end
            REG_START_TIME:
            begin
                sched.start_time_ms = val[TimeW-1:0];
                readback = DataW'(sched.start_time_ms);
            end
            REG_GREEN:
            begin
                sched.green_ms = val[PhaseW-1:0];
                readback = DataW'(sched.green_ms);
            end
            REG_YELLOW:
            begin
                sched.yellow_ms = val[PhaseW-1:0];
                readback = DataW'(sched.yellow_ms);
            end
            REG_RED:
            begin
                sched.red_ms = val[PhaseW-1:0];
                readback = DataW'(sched.red_ms);
            end
            default:
            begin
                known = 1'b0;
                readback = '0;
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(idx * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (known && prdata !== readback)
        begin
            $error("prdata: expected %0h, got %0h", readback, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_time(input logic [HourW-1:0] h, input logic [MinW-1:0] m,
                             input logic [MsW-1:0] ms);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.hour_of_day    <= h;
        in_ch.minute_of_hour <= m;
        in_ch.second_millis  <= ms;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        while (pending_phases.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        phase_res_t want;
        int         stall;
        int         taken;
        bit         recv_burst;
        taken      = 0;
        recv_burst = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            if (taken % 50 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            stall = recv_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            taken++;
            if (pending_phases.size() == 0)
            begin
                $error("result with no item pending: light %0d", out_ch.light);
                mismatch_count++;
            end
            else
            begin
                want = pending_phases.pop_front();
                check_field("light", want.light, out_ch.light);
                check_field("announce", want.announce, out_ch.announce);
                check_field("times_valid", want.times_valid, out_ch.times_valid);
                check_field("phase_left_ms", want.phase_left_ms, out_ch.phase_left_ms);
                check_field("red_in_ms", want.red_in_ms, out_ch.red_in_ms);
            end
        end
    end

    initial
    begin
        step_row_t        rows[$];
        step_row_t        row;
        phase_res_t       want;
        logic [HourW-1:0] h;
        logic [MinW-1:0]  m;
        logic [MsW-1:0]   ms;
        int unsigned      t_ms;
        int unsigned      cyc;
        int unsigned      step_max;
        bit               ticking;

        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.hour_of_day    <= '0;
        in_ch.minute_of_hour <= '0;
        in_ch.second_millis  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = {
            row_time_is(0, 0, 0, phase_is(LIGHT_UNKNOWN, 0, 0, 0, -1)),
            row_time_is(31, 63, 65535, phase_is(LIGHT_UNKNOWN, 0, 0, 0, -1)),
            row_write(REG_SCHEDULE_VALID, 1),
            row_time_is(12, 0, 0, phase_is(LIGHT_UNKNOWN, 0, 0, 0, -1)),
            row_write(REG_START_TIME, 0),
            row_write(REG_GREEN, 10000),
            row_write(REG_YELLOW, 3000),
            row_write(REG_RED, 20000),
            row_time_is(0, 0, 0, phase_is(LIGHT_GREEN, 1, 1, 10000, 10000)),
            row_time_is(0, 0, 9999, phase_is(LIGHT_GREEN, 0, 1, 1, 1)),
            row_time_is(0, 0, 10000, phase_is(LIGHT_RED, 1, 1, 3000, -1)),
            row_time_is(0, 0, 12999, phase_is(LIGHT_RED, 0, 1, 1, -1)),
            row_time_is(0, 0, 13000, phase_is(LIGHT_RED, 0, 1, 20000, -1)),
            row_time_is(0, 0, 32999, phase_is(LIGHT_RED, 0, 1, 1, -1)),
            row_time_is(0, 0, 33000, phase_is(LIGHT_GREEN, 1, 1, 10000, 10000)),
            row_write(REG_START_TIME, 86399999),
            row_time(0, 0, 0),
            row_time(23, 59, 59999),
            row_write(SpareRegIdx, 32'hFFFF_FFFF),
            row_time(31, 63, 65535),
            row_write(REG_START_TIME, 32'hFFFF_FFFF),
            row_write(REG_GREEN, 32'hFFFF_FFFF),
            row_write(REG_YELLOW, 32'hFFFF_FFFF),
            row_write(REG_RED, 32'hFFFF_FFFF),
            row_time(0, 0, 0),
            row_time(31, 63, 65535),
            row_time(12, 34, 56789),
            row_write(REG_START_TIME, 0),
            row_write(REG_GREEN, 1),
            row_write(REG_YELLOW, 1),
            row_write(REG_RED, 1),
            row_time(0, 0, 0),
            row_time(0, 0, 1),
            row_time(0, 0, 2),
            row_write(REG_YELLOW, 0),
            row_time_is(1, 2, 3, phase_is(LIGHT_UNKNOWN, 1, 0, 0, -1)),
            row_write(REG_YELLOW, 5),
            row_write(REG_GREEN, 0),
            row_time_is(1, 2, 4, phase_is(LIGHT_UNKNOWN, 0, 0, 0, -1)),
            row_write(REG_GREEN, 7),
            row_write(REG_RED, 0),
            row_time_is(1, 2, 5, phase_is(LIGHT_UNKNOWN, 0, 0, 0, -1)),
            row_write(REG_RED, 9),
            row_write(REG_SCHEDULE_VALID, 0),
            row_time_is(1, 2, 6, phase_is(LIGHT_UNKNOWN, 0, 0, 0, -1)),
            row_write(REG_SCHEDULE_VALID, 1),
            row_time(5, 5, 5)
        };

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.kind == ROW_WRITE)
            begin
                in_ch.valid <= 1'b0;
                wait_drained();
                write_reg(row.reg_sel, row.wdata);
            end
            else
            begin
                send_time(row.hour, row.minute, row.millis);
                want = predict_phase(row.hour, row.minute, row.millis);
                if (row.typed)
                    want = row.want;
                pending_phases = {pending_phases, want};
            end
        end
        in_ch.valid <= 1'b0;

        for (int ph = 0; ph < RandPhases; ph++)
        begin
            wait_drained();
            write_reg(REG_SCHEDULE_VALID, ($urandom_range(0, 9) != 0));
            write_reg(REG_START_TIME,
                      ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 86399999));
            write_reg(REG_GREEN, draw_phase_len());
            write_reg(REG_YELLOW, draw_phase_len());
            write_reg(REG_RED, draw_phase_len());
            sender_burst = ($urandom_range(0, 3) == 0);
            ticking      = ($urandom_range(0, 9) < 7);
            cyc          = sched.green_ms + sched.yellow_ms + sched.red_ms;
            step_max     = (cyc / 4 + 1 > 100000) ? 100000 : cyc / 4 + 1;
            t_ms         = $urandom_range(0, DayMs - 1);
            for (int n = 0; n < PhaseItems; n++)
            begin
                if (ticking)
                    t_ms = (t_ms + $urandom_range(0, step_max)) % DayMs;
                else
                    t_ms = $urandom_range(0, DayMs - 1);
                h  = HourW'(t_ms / 3600000);
                m  = MinW'((t_ms / 60000) % 60);
                ms = MsW'(t_ms % 60000);
                // Some items carry raw field bits beyond a real time of day.
                if ($urandom_range(0, 9) == 0)
                    {h, m, ms} = $urandom;
                send_time(h, m, ms);
                want = predict_phase(h, m, ms);
                pending_phases = {pending_phases, want};
            end
            in_ch.valid <= 1'b0;
        end

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
